/* rtl/core/radix_digit_emitter_core_assert.svh */
// Assertion macros shared by the radix digit emitter RTL.
// The using module must have a clock named clk and an active-low reset named arst_n.
`ifndef RADIX_DIGIT_EMITTER_CORE_ASSERT_SVH
`define RADIX_DIGIT_EMITTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RDE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RDE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/rde_pkg.sv */
// Package for the radix digit emitter: widths, character codes, register
// indexes, sequencer states and the reciprocal table. No dependencies.
package rde_pkg;

	localparam int VALUE_W          = 32;
	localparam int CHAR_W           = 8;
	localparam int BASE_W           = 5;
	localparam int CFG_DATA_W       = 64;
	localparam int CFG_IDX_W        = 2;
	localparam int DEFAULT_MAX_BASE = 16;
	localparam int SYMS_PER_REG     = CFG_DATA_W / CHAR_W;
	localparam int DIGIT_MAX        = 32;
	localparam int CNT_W            = $clog2(DIGIT_MAX + 1);
	localparam int STACK_IDX_W      = $clog2(DIGIT_MAX);
	localparam int MIN_BASE         = 2;

	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_CORR,
		ST_SIGN,
		ST_EMIT
	} rde_state_t;

	// floor(2^32 / d). The quotient estimate (mag * recip) >> 32 is either
	// exact or one short, so a single correction step fixes it.
	function automatic logic [VALUE_W-1:0] recip_of(input logic [BASE_W-1:0] d);
		logic [VALUE_W-1:0] r;
		case (d)
			5'd2:    r = 32'h8000_0000;
			5'd3:    r = 32'h5555_5555;
			5'd4:    r = 32'h4000_0000;
			5'd5:    r = 32'h3333_3333;
			5'd6:    r = 32'h2AAA_AAAA;
			5'd7:    r = 32'h2492_4924;
			5'd8:    r = 32'h2000_0000;
			5'd9:    r = 32'h1C71_C71C;
			5'd10:   r = 32'h1999_9999;
			5'd11:   r = 32'h1745_D174;
			5'd12:   r = 32'h1555_5555;
			5'd13:   r = 32'h13B1_3B13;
			5'd14:   r = 32'h1249_2492;
			5'd15:   r = 32'h1111_1111;
			5'd16:   r = 32'h1000_0000;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/radix_digit_emitter_core.sv */
// Radix digit emitter top level: renders a signed 32-bit word in a configured base.
// Depends on rde_pkg, rde_alpha_check and radix_digit_emitter_core_assert.svh.
//
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ----------------------
// in        sink       in_valid/in_ready    value (32b signed)
// out       source     out_valid/out_ready  character (8b), last (1b)
// cfg       sink       cfg_wen              cfg_index (2b), cfg_data (64b)
//
// One input word is accepted and its alphabet checked, then each digit passes through
// the shared reciprocal divider (multiply, then correct), and the characters are
// emitted most significant digit first, with a leading minus sign for a negative value.
// in_ready is high only while the sequencer is idle; the output register lets the
// block take the next word while the final character still waits for out_ready.
// Reset clears the configuration registers, the sequencer and the output valid flag.
module radix_digit_emitter_core import rde_pkg::*; #(
	parameter int MAX_BASE = DEFAULT_MAX_BASE
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wen,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [VALUE_W-1:0]   value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [CHAR_W-1:0]           character,
	output logic                        last
);

	`include "radix_digit_emitter_core_assert.svh"

	localparam int DIGIT_W = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;

	// Configuration registers.
	logic [BASE_W-1:0]                base_q;
	logic [MAX_BASE-1:0][CHAR_W-1:0]  sym_q;
	logic                             alpha_ok;

	// Sequencer and divider datapath.
	rde_state_t              state_q, state_d;
	logic                    neg_q;
	logic [VALUE_W-1:0]      mag_q;
	logic [VALUE_W-1:0]      recip_q;
	logic [2*VALUE_W-1:0]    prod_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DIGIT_W-1:0]      stack_q [DIGIT_MAX];

	// Output register.
	logic                    out_valid_q;
	logic [CHAR_W-1:0]       char_q;
	logic                    last_q;

	// Combinational helpers.
	logic [VALUE_W-1:0]      in_mag;
	logic [VALUE_W-1:0]      quot_est;
	logic [2*BASE_W-1:0]     qb_low;
	logic [BASE_W-1:0]       rem_est;
	logic                    rem_over;
	logic [BASE_W-1:0]       digit;
	logic [VALUE_W-1:0]      quot;
	logic [CNT_W-1:0]        top_idx;
	logic                    slot_free;
	logic                    load_out;
	logic [CHAR_W-1:0]       load_char;
	logic                    load_last;

	// Configuration writes. Symbols beyond MAX_BASE are not stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			base_q <= '0;
		else if (cfg_wen && cfg_index == CFG_BASE_SIZE)
			base_q <= cfg_data[BASE_W-1:0];
	end

	for (genvar gi = 0; gi < MAX_BASE; gi++) begin : g_sym
		localparam logic [CFG_IDX_W-1:0] GrpIdx =
			(gi < SYMS_PER_REG) ? CFG_SYMBOLS_LOW : CFG_SYMBOLS_HIGH;
		localparam int ByteLo = CHAR_W * (gi % SYMS_PER_REG);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sym_q[gi] <= '0;
			else if (cfg_wen && cfg_index == GrpIdx)
				sym_q[gi] <= cfg_data[ByteLo +: CHAR_W];
		end
	end

	rde_alpha_check #(
		.MAX_BASE (MAX_BASE)
	) u_alpha_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.base_size (base_q),
		.syms      (sym_q),
		.ok        (alpha_ok)
	);

	// The magnitude is taken in unsigned arithmetic so the minimum integer works.
	assign in_mag = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(unsigned'(value)))
	                                 : VALUE_W'(unsigned'(value));

	// Correction step of the divider. The estimate is at most one short, so the
	// true remainder is below twice the base and fits in the low five bits;
	// only those bits of the product estimate * base are needed.
	assign quot_est = prod_q[2*VALUE_W-1:VALUE_W];
	assign qb_low   = (2*BASE_W)'(quot_est[BASE_W-1:0]) * (2*BASE_W)'(base_q);
	assign rem_est  = mag_q[BASE_W-1:0] - qb_low[BASE_W-1:0];
	assign rem_over = (rem_est >= base_q);
	assign digit    = rem_over ? (rem_est - base_q) : rem_est;
	assign quot     = quot_est + VALUE_W'(rem_over);

	assign top_idx   = cnt_q - CNT_W'(1);
	assign slot_free = !out_valid_q || out_ready;

	// Next state and output load control.
	always_comb begin
		state_d   = state_q;
		load_out  = 1'b0;
		load_char = CH_MINUS;
		load_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = alpha_ok ? ST_MUL : ST_IDLE;
			end
			ST_MUL: begin
				state_d = ST_CORR;
			end
			ST_CORR: begin
				if (quot == '0 || cnt_q == CNT_W'(DIGIT_MAX - 1))
					state_d = neg_q ? ST_SIGN : ST_EMIT;
				else
					state_d = ST_MUL;
			end
			ST_SIGN: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				load_char = sym_q[stack_q[top_idx[STACK_IDX_W-1:0]]];
				load_last = (cnt_q == CNT_W'(1));
				if (slot_free) begin
					load_out = 1'b1;
					if (load_last)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Digit count: grows while dividing, shrinks while emitting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (state_q == ST_IDLE)
			cnt_q <= '0;
		else if (state_q == ST_CORR)
			cnt_q <= cnt_q + CNT_W'(1);
		else if (state_q == ST_EMIT && slot_free)
			cnt_q <= top_idx;
	end

	// Divider datapath. The reciprocal is picked up once per word from the
	// base register, then each digit takes a multiply step and a correct step.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			neg_q <= value[VALUE_W-1];
			mag_q <= in_mag;
		end
		if (state_q == ST_CHECK)
			recip_q <= recip_of(base_q);
		if (state_q == ST_MUL)
			prod_q <= (2*VALUE_W)'(mag_q) * (2*VALUE_W)'(recip_q);
		if (state_q == ST_CORR) begin
			mag_q <= quot;
			stack_q[cnt_q[STACK_IDX_W-1:0]] <= digit[DIGIT_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			char_q <= load_char;
			last_q <= load_last;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	// An accepted word always goes to the alphabet check next.
	`RDE_ASSERT_NEXT(a_accept_to_check, in_valid && in_ready, state_q == ST_CHECK, "accepted word did not enter check")
	// The correction step must leave a digit below the base.
	`RDE_ASSERT_IMP(a_digit_in_range, state_q == ST_CORR, digit < base_q, "divider digit not below base")
	// Emission never runs with an empty digit stack.
	`RDE_ASSERT_IMP(a_emit_nonempty, state_q == ST_EMIT || state_q == ST_SIGN, cnt_q != '0, "emit with no digits")
	// The digit count never exceeds the stack depth.
	`RDE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DIGIT_MAX), "digit count overflow")

endmodule

/* rtl/core/rde_alpha_check.sv */
// Registered validity check of the configured alphabet and base size.
// Depends on rde_pkg.
module rde_alpha_check import rde_pkg::*; #(
	parameter int MAX_BASE = DEFAULT_MAX_BASE
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [BASE_W-1:0]                base_size,
	input  logic [MAX_BASE-1:0][CHAR_W-1:0]  syms,
	output logic                             ok
);

	logic bad;
	logic ok_q;

	// Every pair among the active symbols is compared; sign characters are
	// rejected in every active position.
	always_comb begin
		bad = (base_size < BASE_W'(MIN_BASE)) || (base_size > BASE_W'(MAX_BASE));
		for (int i = 0; i < MAX_BASE; i++) begin
			if (BASE_W'(i) < base_size) begin
				if (syms[i] == CH_PLUS || syms[i] == CH_MINUS)
					bad = 1'b1;
				for (int j = i + 1; j < MAX_BASE; j++) begin
					if (BASE_W'(j) < base_size && syms[i] == syms[j])
						bad = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ok_q <= 1'b0;
		else
			ok_q <= !bad;
	end

	assign ok = ok_q;

endmodule
